/* hw/rtl/upf_pkg.sv */
// upf_pkg: types and constants shared by the UDP payload pattern filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package upf_pkg;

  // longest pattern the search window holds
  localparam int PATTERN_MAX = 8;
  localparam int PAT_W       = 8 * PATTERN_MAX;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  localparam logic [7:0] PROTO_UDP     = 8'd17;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] UDP_HDR_BYTES = 8'd8;

  // configuration register indexes (paddr bit 3)
  localparam logic REG_PATTERN_BYTES  = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  localparam logic [3:0] PATTERN_LENGTH_RST = 4'd5;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } upf_in_t;

  typedef struct packed {
    logic        is_udp;
    logic        pattern_found;
    logic [15:0] payload_length;
    logic [15:0] packet_length;
    logic [31:0] matched_packets;
    logic [31:0] matched_bytes;
  } upf_out_t;

  // control from the parser to the payload search
  typedef struct packed {
    logic go;     // byte lies inside the UDP payload
    logic clear;  // packet ends after this byte
  } upf_search_ctl_t;

  // per-packet summary at the last byte
  typedef struct packed {
    logic        is_udp;
    logic        match;
    logic [15:0] payload_length;
    logic [15:0] packet_length;
  } upf_sum_t;

endpackage

`default_nettype wire

/* hw/rtl/upf_cfg.sv */
// upf_cfg: APB-style configuration registers and effective pattern length.
// Depends on upf_pkg.
`default_nettype none

module upf_cfg
  import upf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic      [63:0]      prdata,
  output logic      [PAT_W-1:0] pattern,
  output logic      [LEN_W-1:0] eff_len
);

  logic [63:0] pat_r;
  logic [3:0]  len_r;
  logic        wr_en;
  logic [3:0]  lim;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= PATTERN_LENGTH_RST;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_PATTERN_BYTES:  pat_r <= pwdata;
        REG_PATTERN_LENGTH: len_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_PATTERN_BYTES:  prdata = pat_r;
      REG_PATTERN_LENGTH: prdata = {60'd0, len_r};
      default:            prdata = '0;
    endcase
  end

  assign pattern = pat_r[PAT_W-1:0];

  // clamp to the window, then cut at the first zero byte (C string end)
  always_comb begin
    lim     = (len_r > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : len_r;
    eff_len = LEN_W'(lim);
    for (int j = PATTERN_MAX - 1; j >= 0; j--) begin
      if (4'(j) < lim && pat_r[8*j +: 8] == 8'd0) eff_len = LEN_W'(j);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/upf_search.sv */
// upf_search: sliding byte window over the UDP payload and pattern compare.
// Depends on upf_pkg.
`default_nettype none

module upf_search
  import upf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire upf_search_ctl_t  ctl,
  input  wire logic [7:0]       data_byte,
  input  wire logic [PAT_W-1:0] pattern,
  input  wire logic [LEN_W-1:0] eff_len,
  output logic                  found_nxt
);

  logic [PAT_W-1:0] win_r, win_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             zero_r, zero_nxt;
  logic             found_r;
  logic [PATTERN_MAX:0] hit;
  logic             shift;

  assign shift = ctl.go && !zero_r && data_byte != 8'd0;

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    zero_nxt = zero_r;
    if (ctl.go && !zero_r) begin
      if (data_byte == 8'd0) begin
        zero_nxt = 1'b1;
      end else begin
        win_nxt = {data_byte, win_r[PAT_W-1:8]};
        if (fill_r < LEN_W'(PATTERN_MAX)) fill_nxt = fill_r + 1'b1;
      end
    end
  end

  // hit[k]: newest k bytes equal the first k pattern bytes, oldest first
  always_comb begin
    hit = '1;
    for (int k = 1; k <= PATTERN_MAX; k++) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (j < k && win_nxt[8*(PATTERN_MAX-k+j) +: 8] != pattern[8*j +: 8]) hit[k] = 1'b0;
      end
    end
  end

  assign found_nxt = found_r ||
                     (shift && eff_len != '0 && fill_nxt >= eff_len && hit[eff_len]);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      win_r   <= '0;
      fill_r  <= '0;
      zero_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      zero_r  <= zero_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/upf_parse.sv */
// upf_parse: IPv4/UDP header tracking per byte and packet summary.
// Depends on upf_pkg and upf_search.
`default_nettype none

module upf_parse
  import upf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire upf_in_t          req,
  input  wire logic [PAT_W-1:0] pattern,
  input  wire logic [LEN_W-1:0] eff_len,
  output upf_sum_t              sum
);

  logic [15:0] pos_r, pos_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic        udp_r, udp_nxt;
  logic [15:0] ulen_r, ulen_nxt;
  logic        active, hdr_go;
  logic [3:0]  hw_eff;
  logic [15:0] hl, start;
  logic [15:0] plen;
  logic [16:0] stop;
  logic        found_nxt;
  logic [7:0]  b;
  upf_search_ctl_t sctl;

  assign b      = req.packet_byte;
  assign active = step && pos_r != 16'hFFFF;
  assign hw_eff = (hw_r < MIN_HDR_WORDS) ? MIN_HDR_WORDS : hw_r;
  assign hl     = {10'd0, hw_eff, 2'b00};
  assign start  = hl + 16'(UDP_HDR_BYTES);
  assign hdr_go = active && udp_r && pos_r >= 16'd10;

  always_comb begin
    pos_nxt  = active ? pos_r + 16'd1 : pos_r;
    hw_nxt   = (active && pos_r == 16'd0) ? b[3:0] : hw_r;
    udp_nxt  = (active && pos_r == 16'd9) ? (b == PROTO_UDP) : udp_r;
    ulen_nxt = ulen_r;
    if (hdr_go && pos_r == hl + 16'd4) ulen_nxt[15:8] = b;
    if (hdr_go && pos_r == hl + 16'd5) ulen_nxt[7:0]  = b;
  end

  assign plen = (ulen_nxt >= 16'(UDP_HDR_BYTES)) ? ulen_nxt - 16'(UDP_HDR_BYTES) : 16'd0;
  assign stop = {1'b0, start} + {1'b0, plen};

  assign sctl.go    = hdr_go && pos_r >= start && {1'b0, pos_r} < stop;
  assign sctl.clear = step && req.last_byte;

  upf_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .data_byte (b),
    .pattern   (pattern),
    .eff_len   (eff_len),
    .found_nxt (found_nxt)
  );

  assign sum.is_udp         = udp_nxt;
  assign sum.match          = udp_nxt && (eff_len == '0 || found_nxt);
  assign sum.payload_length = plen;
  assign sum.packet_length  = pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || sctl.clear) begin
      pos_r  <= '0;
      hw_r   <= '0;
      udp_r  <= 1'b0;
      ulen_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      hw_r   <= hw_nxt;
      udp_r  <= udp_nxt;
      ulen_r <= ulen_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/udp_payload_pattern_filter.sv */
// udp_payload_pattern_filter: top level, input stage, result register, counters.
// Depends on upf_pkg, upf_cfg, upf_parse (and upf_search below it).
//
// Usage
//   in_*  : one IPv4 packet byte per request, starting at the IP header;
//           last_byte marks the end of the packet.
//   out_* : one result request per packet, after its last byte: UDP flag,
//           pattern hit, UDP payload length, bytes seen, running counters
//           of matching packets and their byte total.
//   cfg_* : APB-style port, pattern bytes at 0x0, pattern length at 0x8.
// Timing
//   A byte is held in the input register; the parser and the 8-byte
//   window compare work on it there and load the result register as
//   it steps on, so each result passes the input register and then the
//   result register; a last byte may wait behind a stalled result.
//   One byte per cycle while no last byte is held (single parse/compare stage).
// Reset
//   Synchronous, active low: packet state, counters, pattern (zero) and
//   pattern length (five) go to their defaults; no result is pending.
// Stall
//   While a result waits under out_stall, non-final bytes keep flowing.
//   A last byte waits in the input register, and only then in_stall rises.
`default_nettype none

module udp_payload_pattern_filter
  import upf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire upf_in_t     in_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output upf_out_t         out_rsp,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);

  logic             s1_valid_r, s1_valid_nxt;
  upf_in_t          s1_req_r;
  logic             s1_block, step, in_acc, done;
  logic             out_valid_r, out_valid_nxt;
  upf_out_t         out_rsp_r;
  logic [31:0]      pkt_cnt_r, pkt_cnt_nxt;
  logic [31:0]      byte_cnt_r, byte_cnt_nxt;
  logic [PAT_W-1:0] pattern;
  logic [LEN_W-1:0] eff_len;
  upf_sum_t         sum;

  assign cfg_pready = 1'b1;

  upf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pattern (pattern),
    .eff_len (eff_len)
  );

  // a last byte needs a free (or draining) result register
  assign s1_block = s1_req_r.last_byte && out_valid_r && out_stall;
  assign step     = s1_valid_r && !s1_block;
  assign done     = step && s1_req_r.last_byte;
  assign in_stall = s1_valid_r && s1_block;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)    s1_valid_nxt = 1'b1;
    else if (step) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_req_r <= in_req;
  end

  upf_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .req     (s1_req_r),
    .pattern (pattern),
    .eff_len (eff_len),
    .sum     (sum)
  );

  // running counters move only on matching packets
  always_comb begin
    pkt_cnt_nxt  = pkt_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    if (done && sum.match) begin
      pkt_cnt_nxt  = pkt_cnt_r + 32'd1;
      byte_cnt_nxt = byte_cnt_r + {16'd0, sum.packet_length};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done)                           out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pkt_cnt_r   <= '0;
      byte_cnt_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pkt_cnt_r   <= pkt_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_rsp_r.is_udp          <= sum.is_udp;
      out_rsp_r.pattern_found   <= sum.match;
      out_rsp_r.payload_length  <= sum.payload_length;
      out_rsp_r.packet_length   <= sum.packet_length;
      out_rsp_r.matched_packets <= pkt_cnt_nxt;
      out_rsp_r.matched_bytes   <= byte_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

/* hw/rtl/upf_checker.sv */
// upf_checker: port-level assertions for udp_payload_pattern_filter, with bind.
// Depends on upf_pkg and the top level's ports.
`default_nettype none

module upf_checker
  import upf_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire upf_out_t out_rsp
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  a_found_udp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.pattern_found |-> out_rsp.is_udp)
    else $error("match reported for non-UDP packet");

  a_non_udp_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.is_udp |-> out_rsp.payload_length == 16'd0)
    else $error("payload length on non-UDP packet");

  a_pkt_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.packet_length != 16'd0)
    else $error("empty packet reported");

endmodule

bind udp_payload_pattern_filter upf_checker u_upf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);

`default_nettype wire

/* tb/udp_payload_pattern_filter_tb.sv */
// Self-checking testbench for udp_payload_pattern_filter: directed and random IPv4/UDP
// packet streams, with an in-bench predictor of the per-packet summary and counters.
// Depends on upf_pkg and the udp_payload_pattern_filter RTL only.
`timescale 1ns / 100ps

module udp_payload_pattern_filter_tb;
  import upf_pkg::*;

  // slack that drain() waits after every summary is back
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  upf_in_t     in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  upf_out_t    out_rsp;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  udp_payload_pattern_filter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_rsp     (out_rsp),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the pattern registers, the per-packet
  // parse/search state and the running match counters.
  // ---------------------------------------------------------------------------
  logic [63:0] pat_bytes = '0;
  logic [3:0]  pat_len = PATTERN_LENGTH_RST;

  int unsigned byte_pos;
  logic [3:0]  hdr_words;
  logic        udp_seen;
  logic [15:0] udp_len;
  logic [63:0] window;      // newest payload byte in bits 63..56
  int unsigned window_fill;
  logic        zero_hit;    // search stops at the first zero payload byte
  logic        hit;
  logic [31:0] match_count = '0;
  logic [31:0] match_bytes = '0;

  upf_out_t    pending_summaries[$];  // packet summaries still owed by the block
  logic [7:0]  frame[$];              // packet being built for sending

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_request = 0;      // long receiver hold, set by a test
  int unsigned hold_left = 0;
  int          failures = 0;

  function automatic void clear_packet_state();
    byte_pos    = 0;
    hdr_words   = '0;
    udp_seen    = 1'b0;
    udp_len     = '0;
    window      = '0;
    window_fill = 0;
    zero_hit    = 1'b0;
    hit         = 1'b0;
  endfunction

  // pattern length clipped to the window, cut at an embedded zero byte
  function automatic int unsigned active_pattern_len();
    int unsigned n;
    n = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    for (int unsigned i = 0; i < n; i++)
      if (pat_bytes[8*i +: 8] == 8'h00) return i;
    return n;
  endfunction

  function automatic logic [15:0] udp_payload_len();
    return (udp_len >= 16'd8) ? udp_len - 16'd8 : 16'd0;
  endfunction

  function automatic void search_payload_byte(logic [7:0] b);
    int unsigned n;
    logic [63:0] tail;
    logic [63:0] mask;
    if (zero_hit) return;
    if (b == 8'h00) begin
      zero_hit = 1'b1;
      return;
    end
    window = {b, window[63:8]};
    if (window_fill < 8) window_fill++;
    n = active_pattern_len();
    if (n == 0 || window_fill < n) return;
    tail = window >> (8 * (8 - n));
    mask = (n >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
    if ((tail & mask) == (pat_bytes & mask)) hit = 1'b1;
  endfunction

  function automatic void parse_packet_byte(int unsigned pos, logic [7:0] b);
    int unsigned hl;
    int unsigned first;
    if (pos == 0) hdr_words = b[3:0];
    if (pos == 9) udp_seen = (b == PROTO_UDP);
    if (!udp_seen || pos < 10) return;
    // short IHL is read as the minimal five-word header
    hl = (hdr_words < MIN_HDR_WORDS) ? 20 : 4 * hdr_words;
    if (pos == hl + 4) udp_len[15:8] = b;
    if (pos == hl + 5) udp_len[7:0] = b;
    first = hl + UDP_HDR_BYTES;
    if (pos >= first && pos < first + udp_payload_len()) search_payload_byte(b);
  endfunction

  // runs once per accepted input request, in stream order
  function automatic void track_packet_byte(logic [7:0] b, logic last);
    upf_out_t sum;
    logic match;
    // position saturates; bytes beyond it are neither parsed nor searched
    if (byte_pos < 32'hFFFF) begin
      parse_packet_byte(byte_pos, b);
      byte_pos++;
    end
    if (!last) return;
    match = udp_seen && (active_pattern_len() == 0 || hit);
    if (match) begin
      match_count++;
      match_bytes += byte_pos;
    end
    sum.is_udp          = udp_seen;
    sum.pattern_found   = match;
    sum.payload_length  = udp_payload_len();
    sum.packet_length   = 16'(byte_pos);
    sum.matched_packets = match_count;
    sum.matched_bytes   = match_bytes;
    pending_summaries.push_back(sum);
    clear_packet_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall driver and checker. Outputs are sampled at the falling
  // edge, so a request seen there is taken at the next rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(negedge clk) begin : check_results
    upf_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_summaries.size() == 0) begin
        $error("result with no packet summary pending: %p", out_rsp);
        failures++;
      end else begin
        want = pending_summaries.pop_front();
        check_field("is_udp", 32'(want.is_udp), 32'(out_rsp.is_udp));
        check_field("pattern_found", 32'(want.pattern_found), 32'(out_rsp.pattern_found));
        check_field("payload_length", 32'(want.payload_length),
                    32'(out_rsp.payload_length));
        check_field("packet_length", 32'(want.packet_length), 32'(out_rsp.packet_length));
        check_field("matched_packets", want.matched_packets, out_rsp.matched_packets);
        check_field("matched_bytes", want.matched_bytes, out_rsp.matched_bytes);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and configuration port. All tasks start and end on a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    logic taken;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{packet_byte: b, last_byte: last};
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    track_packet_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  // stop offering requests and wait until every summary is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [63:0] value);
    logic done;
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= {sel, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      done = cfg_pready;
      @(posedge clk);
    end while (!done);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == REG_PATTERN_BYTES) pat_bytes = value;
    else pat_len = value[3:0];
    @(posedge clk);
  endtask

  // registers only change with the block idle and between packets
  task automatic set_pattern(input logic [63:0] bytes, input logic [3:0] len);
    drain();
    write_reg(REG_PATTERN_BYTES, bytes);
    write_reg(REG_PATTERN_LENGTH, {60'd0, len});
  endtask

  // IPv4 header of hw words (min five) plus an 8-byte UDP header, no payload
  task automatic udp_frame(input logic [3:0] hw, input logic [7:0] proto,
                           input logic [15:0] len_field);
    int unsigned hl;
    hl = (hw < MIN_HDR_WORDS) ? 20 : 4 * hw;
    frame.delete();
    frame.push_back({4'h4, hw});
    for (int i = 1; i < hl; i++) frame.push_back((i == 9) ? proto : 8'($urandom));
    repeat (4) frame.push_back(8'($urandom));
    frame.push_back(len_field[15:8]);
    frame.push_back(len_field[7:0]);
    repeat (2) frame.push_back(8'($urandom));
  endtask

  // appends count bytes of data, lowest byte first
  task automatic append(input logic [63:0] data, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) frame.push_back(data[8*i +: 8]);
  endtask

  task automatic trim_frame(input int unsigned keep);
    while (frame.size() > keep) void'(frame.pop_back());
  endtask

  // payload bytes biased toward the pattern so partial matches are common
  function automatic logic [7:0] payload_fill_byte();
    int unsigned n;
    n = active_pattern_len();
    case ($urandom_range(0, 19))
      0: return 8'h00;
      1, 2, 3, 4, 5, 6, 7, 8, 9:
        if (n != 0) return pat_bytes[8*$urandom_range(0, n - 1) +: 8];
      default: ;
    endcase
    return 8'($urandom);
  endfunction

  task automatic add_payload(input int unsigned count);
    int unsigned n;
    int unsigned base;
    int unsigned at;
    base = frame.size();
    repeat (count) frame.push_back(payload_fill_byte());
    n = active_pattern_len();
    if (n != 0 && count >= n && $urandom_range(0, 1) == 1) begin
      at = base + $urandom_range(0, count - n);
      for (int unsigned i = 0; i < n; i++) frame[at + i] = pat_bytes[8*i +: 8];
    end
  endtask

  task automatic random_pattern();
    logic [63:0] bytes;
    logic [3:0]  len;
    for (int i = 0; i < 8; i++) bytes[8*i +: 8] = 8'($urandom_range(1, 255));
    if ($urandom_range(0, 4) == 0) bytes[8*$urandom_range(0, 7) +: 8] = 8'h00;
    len = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
    set_pattern(bytes, len);
  endtask

  // mostly well-formed UDP with random content; the rest is other protocols,
  // truncated packets, trailing junk, odd version nibbles and pure noise
  task automatic random_traffic(input int unsigned min_bytes, input int unsigned min_packets);
    int unsigned sent;
    int unsigned packets;
    int unsigned plen;
    logic [15:0] len_field;
    sent = 0;
    packets = 0;
    while (sent < min_bytes || packets < min_packets) begin
      plen = $urandom_range(0, 16);
      len_field = 16'(plen + 8);
      case ($urandom_range(0, 7))
        0: len_field = 16'($urandom_range(0, 40));
        1: len_field = 16'($urandom);
        default: ;
      endcase
      udp_frame(($urandom_range(0, 3) == 0) ? 4'($urandom) : MIN_HDR_WORDS, PROTO_UDP,
                len_field);
      add_payload(plen);
      case ($urandom_range(0, 9))
        0: frame[9] = 8'($urandom);
        1: trim_frame($urandom_range(1, frame.size()));
        2: begin
          frame.delete();
          repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom));
        end
        3: repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
        4: frame[0] = {4'($urandom), frame[0][3:0]};
        default: ;
      endcase
      send_frame();
      sent += frame.size();
      packets++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset pattern has a zero first byte, so any UDP packet matches
  task automatic test_reset_defaults();
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd12);
    append(64'h0180_00FF, 4);
    send_frame();
    udp_frame(MIN_HDR_WORDS, 8'd6, 16'd10);
    append(64'h00FF, 2);
    send_frame();
  endtask

  task automatic test_short_packets();
    // single byte packet
    frame.delete();
    frame.push_back(8'hFF);
    send_frame();
    // ends right after the protocol byte: UDP, no length seen
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'h0123);
    trim_frame(10);
    send_frame();
    // ends after the length high byte: length reads as 0x0100
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'h0123);
    trim_frame(25);
    send_frame();
    // UDP length below the header size
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd3);
    send_frame();
  endtask

  task automatic test_pattern_rules();
    // empty pattern
    set_pattern(64'h0, 4'd0);
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd11);
    append(64'h00_7733, 3);
    send_frame();
    // full eight-byte pattern, hit and one-short miss
    set_pattern({64{1'b1}}, 4'd8);
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd16);
    append({64{1'b1}}, 8);
    send_frame();
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd16);
    append(64'hFF_FE_FF_FF_FF_FF_FF_FF, 8);
    send_frame();
    // length above the window size acts as eight
    set_pattern({64{1'b1}}, 4'd15);
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd17);
    append(64'hFF_FF_FF_FF_FF_FF_FF_FF, 8);
    append(64'h01, 1);
    send_frame();
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd17);
    append(64'hFF_FF_FF_FF_FF_FF_FF_FE, 8);
    append(64'hFF, 1);
    send_frame();
    // zero inside the pattern cuts it to "AB"
    set_pattern(64'h0000_0000_4300_4241, 4'd4);
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd12);
    append(64'h77_42_41_10, 4);
    send_frame();
    // zero in the payload ends the search
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd11);
    append(64'h42_41_00, 3);
    send_frame();
    // pattern straddles the end of the UDP payload
    udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd10);
    append(64'h42_41_10, 3);
    send_frame();
    // not UDP: no match even with the pattern present
    udp_frame(MIN_HDR_WORDS, 8'd6, 16'd10);
    append(64'h4241, 2);
    send_frame();
    // IHL below five, and the largest IHL
    udp_frame(4'd1, PROTO_UDP, 16'd10);
    append(64'h4241, 2);
    send_frame();
    udp_frame(4'd15, PROTO_UDP, 16'd10);
    append(64'h4241, 2);
    send_frame();
  endtask

  // receiver holds off while packets keep coming, so the block backs up
  // into in_stall; then the sender waits for every summary
  task automatic test_backpressure();
    set_pattern(64'h4241, 4'd2);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    @(negedge clk);
    hold_request = 300;
    @(posedge clk);
    repeat (3) begin
      udp_frame(MIN_HDR_WORDS, PROTO_UDP, 16'd10);
      append(64'h4241, 2);
      send_frame();
    end
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    repeat (2) begin
      random_pattern();
      random_traffic(0, 1);
    end
  endtask

  initial begin
    clear_packet_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_short_packets();
    test_pattern_rules();
    test_backpressure();
    test_random_traffic(25, 48);
    test_random_traffic(48, 25);
    test_random_traffic(0, 0);
    drain();
    if (failures == 0) $display("udp_payload_pattern_filter_tb: PASS");
    else $display("udp_payload_pattern_filter_tb: FAIL");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("udp_payload_pattern_filter_tb: FAIL");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/upf_pkg.sv
hw/rtl/upf_cfg.sv
hw/rtl/upf_search.sv
hw/rtl/upf_parse.sv
hw/rtl/udp_payload_pattern_filter.sv
hw/rtl/upf_checker.sv
tb/udp_payload_pattern_filter_tb.sv
